FILE: design/rgb_hold_fade_cycler_assert.svh
// Assertion macros used by the block's top-level RTL file.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef RGB_HOLD_FADE_CYCLER_ASSERT_SVH
`define RGB_HOLD_FADE_CYCLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RHFC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgb_hold_fade_cycler: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RHFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgb_hold_fade_cycler: next-cycle check failed");

`endif

FILE: design/rhfc_pkg.sv
`default_nettype none

package rhfc_pkg;

    localparam int DT_W       = 20;
    localparam int CH_W       = 8;
    localparam int COLOR_W    = 24;
    localparam int TIME_W     = 31;
    localparam int TLEFT_W    = 33;
    localparam int REP_W      = 16;
    localparam int CYC_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int PHASE_W    = 2;
    localparam int STEP_W     = 4;

    typedef enum logic [PHASE_W-1:0] {
        PH_HOLD_START,
        PH_FADE_UP,
        PH_HOLD_END,
        PH_FADE_DOWN
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_COLOR,
        CFG_END_COLOR,
        CFG_HOLD_START_TIME,
        CFG_FADE_UP_TIME,
        CFG_HOLD_END_TIME,
        CFG_FADE_DOWN_TIME,
        CFG_REPEAT_COUNT
    } cfg_idx_t;

    typedef enum logic [3:0] {
        U_WAIT,
        U_INIT,
        U_DIV_LOAD,
        U_DIV_WAIT,
        U_DIV_STORE,
        U_ENTER_FIRST,
        U_EMIT,
        U_DEC,
        U_MAC,
        U_ENTER_NEXT
    } uop_t;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t L_WAIT        = 4'd0;
    localparam step_t L_INIT        = 4'd1;
    localparam step_t L_DIV_LOAD    = 4'd2;
    localparam step_t L_DIV_WAIT    = 4'd3;
    localparam step_t L_DIV_STORE   = 4'd4;
    localparam step_t L_ENTER_FIRST = 4'd5;
    localparam step_t L_TICK        = 4'd6;
    localparam step_t L_DEC         = 4'd7;
    localparam step_t L_MAC         = 4'd8;
    localparam step_t L_NEXT        = 4'd9;

    typedef struct packed {
        uop_t  op;
        step_t jump;
    } ctl_word_t;

    // Control store. The jump field is taken only when the operation's condition says so.
    function automatic ctl_word_t rhfc_ucode(input step_t step);
        ctl_word_t cw;
        case (step)
            L_WAIT:        cw = '{op: U_WAIT,        jump: L_TICK};
            L_INIT:        cw = '{op: U_INIT,        jump: L_DIV_LOAD};
            L_DIV_LOAD:    cw = '{op: U_DIV_LOAD,    jump: L_DIV_WAIT};
            L_DIV_WAIT:    cw = '{op: U_DIV_WAIT,    jump: L_DIV_STORE};
            L_DIV_STORE:   cw = '{op: U_DIV_STORE,   jump: L_DIV_LOAD};
            L_ENTER_FIRST: cw = '{op: U_ENTER_FIRST, jump: L_TICK};
            L_TICK:        cw = '{op: U_EMIT,        jump: L_NEXT};
            L_DEC:         cw = '{op: U_DEC,         jump: L_MAC};
            L_MAC:         cw = '{op: U_MAC,         jump: L_MAC};
            L_NEXT:        cw = '{op: U_ENTER_NEXT,  jump: L_WAIT};
            default:       cw = '{op: U_WAIT,        jump: L_TICK};
        endcase
        return cw;
    endfunction

    function automatic logic [CH_W-1:0] rhfc_chan(input logic [COLOR_W-1:0] color,
                                                  input logic [1:0] ch);
        logic [CH_W-1:0] v;
        case (ch)
            2'd0:    v = color[23:16];
            2'd1:    v = color[15:8];
            default: v = color[7:0];
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: design/rhfc_tick_if.sv
`default_nettype none

interface rhfc_tick_if
    import rhfc_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [DT_W-1:0] delta_time;

    modport source (output valid, output delta_time, input ready);
    modport sink   (input valid, input delta_time, output ready);
endinterface

`default_nettype wire

FILE: design/rhfc_pix_if.sv
`default_nettype none

interface rhfc_pix_if
    import rhfc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CH_W-1:0]    red;
    logic [CH_W-1:0]    green;
    logic [CH_W-1:0]    blue;
    logic               active;
    logic [PHASE_W-1:0] phase_now;

    modport source (output valid, output red, output green, output blue, output active,
                    output phase_now, input ready);
    modport sink   (input valid, input red, input green, input blue, input active,
                    input phase_now, output ready);
endinterface

`default_nettype wire

FILE: design/rgb_hold_fade_cycler.sv
// Channel   Dir  Handshake      Payload
// tick      in   valid/ready    delta_time[19:0]
// pix       out  valid/ready    red, green, blue [7:0], active, phase_now[1:0]
// cfg       in   cfg_we only    cfg_index[2:0], cfg_data[30:0]
// The first tick after reset runs the start program: six serial divisions of
// FRAC_BITS + 8 quotient bits each. After that a tick runs the emit step, then
// the time decrement and, in a fade phase, the channel multiply-accumulates on
// the one shared multiplier; a phase change enters the next phase instead.
// A full output register holds the sequencer at the emit step until a transfer.
// Reset is asynchronous and active low and needs no clearing pass.
`default_nettype none
`include "rgb_hold_fade_cycler_assert.svh"

module rgb_hold_fade_cycler
    import rhfc_pkg::*;
#(
    parameter int FRAC_BITS = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    rhfc_tick_if.sink             tick,
    rhfc_pix_if.source            pix
);

    localparam int ACC_W  = CH_W + FRAC_BITS;
    localparam int RATE_W = ACC_W + 1;
    localparam int PROD_W = RATE_W + DT_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam logic [ACC_W-1:0] TOP = {{CH_W{1'b1}}, {FRAC_BITS{1'b0}}};

    logic [COLOR_W-1:0]        start_color_reg;
    logic [COLOR_W-1:0]        end_color_reg;
    logic [TIME_W-1:0]         times_reg [4];
    logic [REP_W-1:0]          repeat_count_reg;

    step_t                     upc_reg;
    step_t                     upc_next;
    ctl_word_t                 cw;

    logic                      started_reg;
    phase_t                    phase_reg;
    phase_t                    first_reg;
    logic signed [TLEFT_W-1:0] time_left_reg;
    logic [ACC_W-1:0]          acc_reg [3];
    logic signed [RATE_W-1:0]  rate_up_reg [3];
    logic signed [RATE_W-1:0]  rate_down_reg [3];
    logic signed [CYC_W-1:0]   cycles_left_reg;
    logic [1:0]                ch_reg;
    logic                      dir_reg;
    logic [DT_W-1:0]           dt_reg;
    logic signed [PROD_W-1:0]  prod_reg;

    logic                      out_valid_reg;
    logic [CH_W-1:0]           red_reg;
    logic [CH_W-1:0]           green_reg;
    logic [CH_W-1:0]           blue_reg;
    logic                      active_reg;
    phase_t                    phase_out_reg;

    logic                      accept;
    logic                      slot_free;
    logic                      finished;
    logic                      time_pos;
    logic                      is_fade;
    logic                      emit_fire;
    logic                      div_start;
    logic                      div_done;
    logic [ACC_W-1:0]          div_num;
    logic [TIME_W-1:0]         div_den;
    logic [ACC_W-1:0]          div_quot;
    logic signed [CH_W:0]      diff;
    logic [CH_W-1:0]           diff_mag;
    logic                      rate_neg;
    logic signed [RATE_W-1:0]  rate_new;
    phase_t                    next_ph;
    phase_t                    first_search;
    phase_t                    enter_ph;
    logic [COLOR_W-1:0]        enter_src;
    logic [1:0]                mul_ch;
    logic [1:0]                mac_idx;
    logic signed [RATE_W-1:0]  rate_sel;
    logic signed [PROD_W-1:0]  mul_out;
    logic [ACC_W-1:0]          acc_cur;
    logic signed [SUM_W-1:0]   sum;
    logic [ACC_W-1:0]          acc_clamped;

    assign cw        = rhfc_ucode(upc_reg);
    assign accept    = tick.valid && tick.ready;
    assign slot_free = !out_valid_reg || pix.ready;
    assign finished  = cycles_left_reg[CYC_W-1];
    assign time_pos  = time_left_reg > 0;
    assign is_fade   = (phase_reg == PH_FADE_UP) || (phase_reg == PH_FADE_DOWN);

    // Sequencer: step counter and conditional jumps.
    always_comb
    begin
        upc_next   = upc_reg + STEP_W'(1);
        tick.ready = 1'b0;
        div_start  = 1'b0;
        emit_fire  = 1'b0;
        case (cw.op)
            U_WAIT:
            begin
                tick.ready = 1'b1;
                if (!accept)
                    upc_next = upc_reg;
                else if (started_reg)
                    upc_next = cw.jump;
            end
            U_INIT: ;
            U_DIV_LOAD:
                div_start = 1'b1;
            U_DIV_WAIT:
                if (!div_done)
                    upc_next = upc_reg;
            U_DIV_STORE:
                if (!(dir_reg && ch_reg == 2'd2))
                    upc_next = cw.jump;
            U_ENTER_FIRST: ;
            U_EMIT:
            begin
                if (!slot_free)
                    upc_next = upc_reg;
                else
                begin
                    emit_fire = 1'b1;
                    if (finished)
                        upc_next = L_WAIT;
                    else if (!time_pos)
                        upc_next = cw.jump;
                end
            end
            U_DEC:
                if (!is_fade)
                    upc_next = L_WAIT;
            U_MAC:
                if (ch_reg == 2'd3)
                    upc_next = L_WAIT;
                else
                    upc_next = cw.jump;
            U_ENTER_NEXT:
                upc_next = L_WAIT;
            default:
                upc_next = L_WAIT;
        endcase
    end

    // Phase search for the start program and for cyclic advance.
    always_comb
    begin
        logic [1:0] cand;
        next_ph      = phase_reg;
        first_search = PH_HOLD_START;
        for (int k = 3; k >= 1; k--)
        begin
            cand = 2'(phase_reg + 2'(k));
            if (times_reg[cand] != '0)
                next_ph = phase_t'(cand);
        end
        for (int p = 3; p >= 0; p--)
        begin
            if (times_reg[p] != '0)
                first_search = phase_t'(p);
        end
    end

    assign enter_ph  = (cw.op == U_ENTER_FIRST) ? first_reg : next_ph;
    assign enter_src = (enter_ph == PH_HOLD_START || enter_ph == PH_FADE_UP) ?
                       start_color_reg : end_color_reg;

    // Rate division operands.
    assign diff     = $signed({1'b0, rhfc_chan(end_color_reg, ch_reg)})
                    - $signed({1'b0, rhfc_chan(start_color_reg, ch_reg)});
    assign diff_mag = diff[CH_W] ? CH_W'(-diff) : diff[CH_W-1:0];
    assign rate_neg = dir_reg ? (diff > 0) : (diff < 0);
    assign div_num  = {diff_mag, {FRAC_BITS{1'b0}}};
    assign div_den  = dir_reg ? times_reg[3] : times_reg[1];
    assign rate_new = rate_neg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});

    rhfc_div #(
        .NUM_W (ACC_W),
        .DEN_W (TIME_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Shared multiplier and clamped accumulate.
    assign mul_ch  = (cw.op == U_DEC) ? 2'd0 : ch_reg;
    assign mac_idx = ch_reg - 2'd1;

    always_comb
    begin
        rate_sel = '0;
        acc_cur  = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (mul_ch == 2'(i))
                rate_sel = (phase_reg == PH_FADE_UP) ? rate_up_reg[i] : rate_down_reg[i];
            if (mac_idx == 2'(i))
                acc_cur = acc_reg[i];
        end
    end

    assign mul_out = rate_sel * $signed({1'b0, dt_reg});
    assign sum     = $signed({{(SUM_W-ACC_W){1'b0}}, acc_cur}) + SUM_W'(prod_reg);

    always_comb
    begin
        if (sum > $signed({{(SUM_W-ACC_W){1'b0}}, TOP}))
            acc_clamped = TOP;
        else if (sum < 0)
            acc_clamped = '0;
        else
            acc_clamped = sum[ACC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_color_reg  <= '0;
            end_color_reg    <= '0;
            times_reg        <= '{default: '0};
            repeat_count_reg <= '0;
            upc_reg          <= L_WAIT;
            started_reg      <= 1'b0;
            phase_reg        <= PH_HOLD_START;
            first_reg        <= PH_HOLD_START;
            time_left_reg    <= '0;
            acc_reg          <= '{default: '0};
            rate_up_reg      <= '{default: '0};
            rate_down_reg    <= '{default: '0};
            cycles_left_reg  <= '0;
            ch_reg           <= '0;
            dir_reg          <= 1'b0;
            dt_reg           <= '0;
            prod_reg         <= '0;
            out_valid_reg    <= 1'b0;
            red_reg          <= '0;
            green_reg        <= '0;
            blue_reg         <= '0;
            active_reg       <= 1'b0;
            phase_out_reg    <= PH_HOLD_START;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_START_COLOR:     start_color_reg  <= cfg_data[COLOR_W-1:0];
                    CFG_END_COLOR:       end_color_reg    <= cfg_data[COLOR_W-1:0];
                    CFG_HOLD_START_TIME: times_reg[0]     <= cfg_data;
                    CFG_FADE_UP_TIME:    times_reg[1]     <= cfg_data;
                    CFG_HOLD_END_TIME:   times_reg[2]     <= cfg_data;
                    CFG_FADE_DOWN_TIME:  times_reg[3]     <= cfg_data;
                    CFG_REPEAT_COUNT:    repeat_count_reg <= cfg_data[REP_W-1:0];
                    default: ;
                endcase
            end

            upc_reg <= upc_next;

            if (accept)
                dt_reg <= tick.delta_time;

            if (pix.ready)
                out_valid_reg <= 1'b0;
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
                red_reg       <= finished ? '0 : acc_reg[0][ACC_W-1 -: CH_W];
                green_reg     <= finished ? '0 : acc_reg[1][ACC_W-1 -: CH_W];
                blue_reg      <= finished ? '0 : acc_reg[2][ACC_W-1 -: CH_W];
                active_reg    <= !finished;
                phase_out_reg <= finished ? PH_HOLD_START : phase_reg;
            end

            case (cw.op)
                U_INIT:
                begin
                    first_reg       <= first_search;
                    cycles_left_reg <= $signed({1'b0, repeat_count_reg});
                    started_reg     <= 1'b1;
                    ch_reg          <= '0;
                    dir_reg         <= 1'b0;
                end
                U_DIV_STORE:
                begin
                    if (dir_reg)
                    begin
                        rate_down_reg[ch_reg] <= rate_new;
                        ch_reg                <= ch_reg + 2'd1;
                        dir_reg               <= 1'b0;
                    end
                    else
                    begin
                        rate_up_reg[ch_reg] <= rate_new;
                        dir_reg             <= 1'b1;
                    end
                end
                U_ENTER_FIRST, U_ENTER_NEXT:
                begin
                    phase_reg     <= enter_ph;
                    time_left_reg <= $signed({{(TLEFT_W-TIME_W){1'b0}}, times_reg[enter_ph]});
                    if (enter_ph == first_reg)
                        cycles_left_reg <= cycles_left_reg - CYC_W'(1);
                    for (int i = 0; i < 3; i++)
                        acc_reg[i] <= {rhfc_chan(enter_src, 2'(i)), {FRAC_BITS{1'b0}}};
                end
                U_DEC:
                begin
                    time_left_reg <= time_left_reg
                                   - $signed({{(TLEFT_W-DT_W){1'b0}}, dt_reg});
                    prod_reg      <= mul_out;
                    ch_reg        <= 2'd1;
                end
                U_MAC:
                begin
                    for (int i = 0; i < 3; i++)
                        if (mac_idx == 2'(i))
                            acc_reg[i] <= acc_clamped;
                    prod_reg <= mul_out;
                    ch_reg   <= ch_reg + 2'd1;
                end
                default: ;
            endcase
        end
    end

    assign pix.valid     = out_valid_reg;
    assign pix.red       = red_reg;
    assign pix.green     = green_reg;
    assign pix.blue      = blue_reg;
    assign pix.active    = active_reg;
    assign pix.phase_now = phase_out_reg;

    `RHFC_ASSERT_NEXT(a_one_tick_at_a_time, accept, !tick.ready)
    `RHFC_ASSERT_IMPLY(a_finished_is_blank, pix.valid && !pix.active, pix.red == '0 && pix.green == '0 && pix.blue == '0 && pix.phase_now == '0)
    `RHFC_ASSERT_IMPLY(a_acc_clamped, 1'b1, acc_reg[0] <= TOP && acc_reg[1] <= TOP && acc_reg[2] <= TOP)
    `RHFC_ASSERT_IMPLY(a_div_done_in_wait, div_done, cw.op == U_DIV_WAIT)
    `RHFC_ASSERT_NEXT(a_finished_sticks, finished, finished)

endmodule

`default_nettype wire

FILE: design/rhfc_div.sv
`default_nettype none

module rhfc_div
    import rhfc_pkg::*;
#(
    parameter int NUM_W = 32,
    parameter int DEN_W = 31
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] quot_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(NUM_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg  <= cnt_reg - CNT_W'(1);
                done_reg <= (cnt_reg == CNT_W'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            num_reg  <= num_reg << 1;
            rem_reg  <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quot_reg <= {quot_reg[NUM_W-2:0], fits};
        end
    end

    // A zero fade time yields a zero rate.
    assign quot = (den_reg == '0) ? '0 : quot_reg;
    assign done = done_reg;

endmodule

`default_nettype wire
